// ===== hw/rtl/q24_8_fixed_point_alu_unit_assert.svh =====
// assertion macros for the q24.8 alu
`ifndef Q24_8_FIXED_POINT_ALU_UNIT_ASSERT_SVH
`define Q24_8_FIXED_POINT_ALU_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define Q24_ASSERT(lbl, c, r, p) \
  lbl: assert property (@(posedge c) disable iff (r) (p)) else $error("q24 alu check failed");
`define Q24_ASSERT_ALWAYS(lbl, c, p) \
  lbl: assert property (@(posedge c) (p)) else $error("q24 alu check failed");
`else
`define Q24_ASSERT(lbl, c, r, p)
`define Q24_ASSERT_ALWAYS(lbl, c, p)
`endif
`endif

// ===== hw/rtl/q24alu_pkg.sv =====
// types, codes and helpers shared by the q24.8 alu
package q24alu_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DW        = 32 + FRAC_BITS;

  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MUL  = 4'd2;
  localparam logic [3:0] OP_DIV  = 4'd3;
  localparam logic [3:0] OP_GT   = 4'd4;
  localparam logic [3:0] OP_LT   = 4'd5;
  localparam logic [3:0] OP_GE   = 4'd6;
  localparam logic [3:0] OP_LE   = 4'd7;
  localparam logic [3:0] OP_EQ   = 4'd8;
  localparam logic [3:0] OP_NE   = 4'd9;
  localparam logic [3:0] OP_MIN  = 4'd10;
  localparam logic [3:0] OP_MAX  = 4'd11;
  localparam logic [3:0] OP_INC  = 4'd12;
  localparam logic [3:0] OP_DEC  = 4'd13;
  localparam logic [3:0] OP_TOI  = 4'd14;
  localparam logic [3:0] OP_FROMI = 4'd15;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  localparam logic signed [31:0] MAX32 = 32'sh7fffffff;
  localparam logic signed [31:0] MIN32 = 32'sh80000000;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_true;
    logic [1:0]         status;
  } rsp_t;

  // signed result from a magnitude and sign, clamped to 32 bits
  function automatic rsp_t sat_mag(logic [63:0] m, logic neg);
    rsp_t r;
    r.compare_true = 1'b0;
    r.status       = ST_OK;
    if (neg) begin
      if (m > 64'h8000_0000) begin
        r.result_value = MIN32;
        r.status       = ST_OVF;
      end else begin
        r.result_value = -$signed(m[31:0]);
      end
    end else begin
      if (m > 64'h7fff_ffff) begin
        r.result_value = MAX32;
        r.status       = ST_OVF;
      end else begin
        r.result_value = $signed(m[31:0]);
      end
    end
    return r;
  endfunction

  // clamp a 33-bit signed sum
  function automatic rsp_t sat33(logic signed [32:0] s);
    rsp_t r;
    r.compare_true = 1'b0;
    r.status       = ST_OK;
    if (s[32] != s[31]) begin
      r.result_value = s[32] ? MIN32 : MAX32;
      r.status       = ST_OVF;
    end else begin
      r.result_value = s[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/q24alu_div.sv =====
// restoring divider, one quotient bit per pipeline stage
module q24alu_div import q24alu_pkg::*; (
  input  logic          clk,
  input  logic [DW-1:0] num,
  input  logic [31:0]   den,
  output logic [DW-1:0] quo,
  output logic [31:0]   rem,
  output logic [31:0]   den_out
);

  // w holds the dividend bits still to shift in, quotient bits fill from below
  logic [DW-1:0] w [0:DW];
  logic [31:0]   r [0:DW];
  logic [31:0]   d [0:DW];

  assign w[0] = num;
  assign r[0] = '0;
  assign d[0] = den;

  for (genvar i = 0; i < DW; i++) begin : g_stage
    logic [32:0] sh;
    logic [32:0] diff;
    logic        ge;
    assign sh   = {r[i], w[i][DW-1]};
    assign diff = sh - {1'b0, d[i]};
    assign ge   = sh >= {1'b0, d[i]};
    always_ff @(posedge clk) begin
      w[i+1] <= {w[i][DW-2:0], ge};
      r[i+1] <= ge ? diff[31:0] : sh[31:0];
      d[i+1] <= d[i];
    end
  end

  assign quo     = w[DW];
  assign rem     = r[DW];
  assign den_out = d[DW];

endmodule

// ===== hw/rtl/q24_8_fixed_point_alu_unit.sv =====
// q24.8 fixed-point alu top level, fully pipelined
//
// usage:
//   drive req (opcode, operand_a, operand_b) and raise start; the transaction
//   is taken at the clock edge where start is high and busy is low. busy stays
//   low, so a new transaction can be started on every cycle.
//   each result appears on rsp for exactly one cycle with done high; the
//   receiver cannot stall and must take it in that cycle.
//   results come back in issue order.
// depth: every transaction passes the request register, the divider stages
//   or the side line beside them, and the output register, whatever its
//   opcode. the depth is set by the divider, which resolves one quotient bit
//   per stage over the 32 + FRAC_BITS bit scaled dividend.
// throughput: one transaction per cycle.
// reset: rst (synchronous, active high) drops every in-flight transaction;
//   done is low on the cycle after reset. the data registers are not reset.
// status: 0 ok, 1 saturated on overflow, 2 divide by zero (result 0).
module q24_8_fixed_point_alu_unit import q24alu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  typedef struct packed {
    logic [3:0] op;
    logic       neg;
    logic       bzero;
    rsp_t       res;
  } info_t;

  localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

  // stage 0: registered request and operand magnitudes
  logic               v0;
  logic [3:0]         op0;
  logic signed [31:0] a0;
  logic signed [31:0] b0;
  logic [31:0]        ma0;
  logic [31:0]        mb0;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    op0 <= req.opcode;
    a0  <= req.operand_a;
    b0  <= req.operand_b;
    ma0 <= req.operand_a[31] ? $unsigned(~req.operand_a + 32'sd1) : $unsigned(req.operand_a);
    mb0 <= req.operand_b[31] ? $unsigned(~req.operand_b + 32'sd1) : $unsigned(req.operand_b);
  end

  // divider runs from stage 0 for DW stages
  logic [DW-1:0] quo;
  logic [31:0]   rem;
  logic [31:0]   den;

  q24alu_div u_div (
    .clk     (clk),
    .num     ({ma0, {FRAC_BITS{1'b0}}}),
    .den     (mb0),
    .quo     (quo),
    .rem     (rem),
    .den_out (den)
  );

  // simple operations resolved from stage 0
  info_t info1_next;
  logic [31:0] ti_mag;

  assign ti_mag = ma0 >> FRAC_BITS;

  always_comb begin
    info1_next.op    = op0;
    info1_next.bzero = (b0 == 32'sd0);
    info1_next.neg   = a0[31] ^ b0[31];
    info1_next.res   = '0;
    unique case (op0)
      OP_ADD: info1_next.res = sat33(33'(a0) + 33'(b0));
      OP_SUB: info1_next.res = sat33(33'(a0) - 33'(b0));
      OP_INC: info1_next.res = sat33(33'(a0) + 33'sd1);
      OP_DEC: info1_next.res = sat33(33'(a0) - 33'sd1);
      OP_GT:  info1_next.res.compare_true = a0 > b0;
      OP_LT:  info1_next.res.compare_true = a0 < b0;
      OP_GE:  info1_next.res.compare_true = a0 >= b0;
      OP_LE:  info1_next.res.compare_true = a0 <= b0;
      OP_EQ:  info1_next.res.compare_true = a0 == b0;
      OP_NE:  info1_next.res.compare_true = a0 != b0;
      OP_MIN: info1_next.res.result_value = (a0 <= b0) ? a0 : b0;
      OP_MAX: info1_next.res.result_value = (a0 >= b0) ? a0 : b0;
      OP_TOI: info1_next.res.result_value =
                a0[31] ? -$signed(ti_mag) : $signed(ti_mag);
      OP_FROMI: info1_next.res = sat_mag(64'({ma0, {FRAC_BITS{1'b0}}}), a0[31]);
      OP_MUL, OP_DIV: info1_next.res = '0;
      default: info1_next.res = '0;
    endcase
  end

  // side line that keeps every transaction in step with the divider
  logic [DW:1] vl;
  info_t       line [1:DW];
  logic [63:0] prod;
  info_t       info2_next;

  always_comb begin
    info2_next = line[1];
    if (line[1].op == OP_MUL) begin
      info2_next.res = sat_mag((prod + HALF) >> FRAC_BITS, line[1].neg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vl <= '0;
    end else begin
      vl <= {vl[DW-1:1], v0};
    end
  end

  always_ff @(posedge clk) begin
    prod    <= 64'(ma0) * 64'(mb0);
    line[1] <= info1_next;
    line[2] <= info2_next;
  end

  for (genvar k = 3; k <= DW; k++) begin : g_line
    always_ff @(posedge clk) begin
      line[k] <= line[k-1];
    end
  end

  // final stage: divide rounding and output register
  rsp_t        rsp_next;
  logic [63:0] qr;

  assign qr = 64'(quo) + 64'(rem >= (den - rem));

  always_comb begin
    rsp_next = line[DW].res;
    if (line[DW].op == OP_DIV) begin
      if (line[DW].bzero) begin
        rsp_next.result_value = '0;
        rsp_next.compare_true = 1'b0;
        rsp_next.status       = ST_DIVZ;
      end else begin
        rsp_next = sat_mag(qr, line[DW].neg);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vl[DW];
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

`include "q24_8_fixed_point_alu_unit_assert.svh"

  `Q24_ASSERT(a_divz_zero, clk, rst, done && rsp.status == ST_DIVZ |-> rsp.result_value == 32'sd0)
  `Q24_ASSERT(a_cmp_clean, clk, rst, done && rsp.compare_true |-> rsp.status == ST_OK && rsp.result_value == 32'sd0)
  `Q24_ASSERT(a_ovf_rail, clk, rst, done && rsp.status == ST_OVF |-> rsp.result_value == MAX32 || rsp.result_value == MIN32)
  `Q24_ASSERT_ALWAYS(a_rst_done, clk, $past(rst) |-> !done)

endmodule
